### src/beu_pkg.sv
// Shared types, constants and command codes for the bytecode execute unit.
`timescale 1ns / 1ps
package beu_pkg;

   localparam int VarCountDef   = 256;
   localparam int ArrayCountDef = 16;
   localparam int ArrayDepthDef = 1024;
   localparam int SkipBitsDef   = 16;
   localparam int WordBits      = 32;

   typedef enum logic [4:0] {
      CMD_SET = 5'd0, CMD_IF = 5'd1, CMD_END = 5'd2, CMD_ADD = 5'd3, CMD_SUB = 5'd4,
      CMD_MUL = 5'd5, CMD_DIV = 5'd6, CMD_MOD = 5'd7, CMD_ALLOC = 5'd8, CMD_FREE = 5'd9,
      CMD_ASTORE = 5'd10, CMD_ALOAD = 5'd11, CMD_INC = 5'd12, CMD_DEC = 5'd13,
      CMD_PNUM = 5'd14, CMD_PCHAR = 5'd15, CMD_RNUM = 5'd16, CMD_RCHAR = 5'd17,
      CMD_JUMP = 5'd18, CMD_NOP = 5'd19
   } cmd_type;

   localparam logic [2:0] REL_GT = 3'd0, REL_LT = 3'd1, REL_EQ = 3'd2, REL_NE = 3'd3,
                          REL_LE = 3'd4, REL_GE = 3'd5;

   localparam logic [1:0] KIND_NONE = 2'd0, KIND_NUM = 2'd1, KIND_CHAR = 2'd2;
   localparam logic [1:0] ERR_NONE = 2'd0, ERR_VAR = 2'd1, ERR_ARR = 2'd2, ERR_DIV = 2'd3;

   typedef struct packed {
      logic [4:0]  command;
      logic [2:0]  relation;
      logic        first_is_var;
      logic        second_is_var;
      logic [31:0] word_a;
      logic [31:0] word_b;
      logic [31:0] word_c;
      logic [31:0] input_value;
   } item_type;

   typedef struct packed {
      logic [1:0]  print_kind;
      logic [31:0] print_value;
      logic        redirect;
      logic [15:0] redirect_target;
      logic        skipped;
      logic [1:0]  error;
   } result_type;

endpackage

### src/beu_front.sv
// Input stage and two-entry item queue feeding the execute engine.
`timescale 1ns / 1ps
module beu_front
   import beu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  item_type    req_item,
   output logic        q_valid,
   input  logic        q_pop,
   output item_type    q_item
);
   item_type   mem_ff [2];
   logic [0:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = q_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= req_item;
   end
endmodule

### src/beu_divider.sv
// Iterative signed 32-bit divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module beu_divider
   import beu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);
   logic [31:0] q_ff, q_in, d_ff, d_in;
   logic [32:0] r_ff, r_in;
   logic [5:0]  n_ff, n_in;
   logic        busy_ff, busy_in, qn_ff, qn_in, rn_ff, rn_in, done_ff, done_in;
   logic [32:0] trial;
   logic [32:0] shifted;

   always_comb begin
      q_in = q_ff; d_in = d_ff; r_in = r_ff; n_in = n_ff;
      busy_in = busy_ff; qn_in = qn_ff; rn_in = rn_ff; done_in = 1'b0;
      shifted = {r_ff[31:0], q_ff[31]};
      trial   = shifted - {1'b0, d_ff};
      if (start) begin
         q_in    = dividend[31] ? 32'(-dividend) : dividend;
         d_in    = divisor[31] ? 32'(-divisor) : divisor;
         r_in    = '0;
         n_in    = 6'd32;
         busy_in = 1'b1;
         qn_in   = dividend[31] ^ divisor[31];
         rn_in   = dividend[31];
      end else if (busy_ff) begin
         if (!trial[32]) begin
            r_in = trial;
            q_in = {q_ff[30:0], 1'b1};
         end else begin
            r_in = shifted;
            q_in = {q_ff[30:0], 1'b0};
         end
         n_in = n_ff - 6'd1;
         if (n_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff  <= q_in;
      d_ff  <= d_in;
      r_ff  <= r_in;
      n_ff  <= n_in;
      qn_ff <= qn_in;
      rn_ff <= rn_in;
   end

   assign done      = done_ff;
   assign quotient  = qn_ff ? 32'(-q_ff) : q_ff;
   assign remainder = rn_ff ? 32'(-r_ff[31:0]) : r_ff[31:0];
endmodule

### src/beu_back.sv
// Execute engine: operand fetch, checks, arithmetic, store writes, result register.
`timescale 1ns / 1ps
module beu_back
   import beu_pkg::*;
#(
   parameter int VAR_COUNT   = VarCountDef,
   parameter int ARRAY_COUNT = ArrayCountDef,
   parameter int ARRAY_DEPTH = ArrayDepthDef,
   parameter int SKIP_BITS   = SkipBitsDef
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   output logic       q_pop,
   input  item_type   q_item,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_result
);
   localparam int VarBits   = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
   localparam int ArrTotal  = ARRAY_COUNT * ARRAY_DEPTH;
   localparam int ArrBits   = (ArrTotal > 1) ? $clog2(ArrTotal) : 1;
   localparam int IdxBits   = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
   localparam int NumBits   = (ARRAY_COUNT > 1) ? $clog2(ARRAY_COUNT) : 1;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_RD1   = 9'b000000010,
      ST_RD2   = 9'b000000100,
      ST_RD3   = 9'b000001000,
      ST_EXEC  = 9'b000010000,
      ST_ARD   = 9'b000100000,
      ST_DIV   = 9'b001000000,
      ST_MUL   = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   state_type  st_ff, st_in;
   item_type   it_ff;
   logic [31:0] vars_mem [VAR_COUNT];
   logic [31:0] arr_mem  [ArrTotal];
   logic [31:0] x_ff, y_ff, dst_ff, vrd_ff, ard_ff, prod_ff;
   logic [VarBits-1:0] vaddr;
   logic               vwe;
   logic [31:0]        vwdata;
   logic [ArrBits-1:0] aaddr_ff, aaddr_in;
   logic               awe;
   logic [SKIP_BITS-1:0] skip_ff, skip_in;
   result_type res_ff, res_in;
   logic       ovalid_ff;
   logic       div_start, div_done;
   logic [31:0] div_q, div_r;
   logic        xok_ff, yok_ff;
   logic        ald_ff;

   function automatic logic var_ok(input logic [31:0] w);
      return !w[31] && ({1'b0, w} < 33'(VAR_COUNT));
   endfunction
   function automatic logic cnt_ok(input logic [31:0] w, input int lim);
      return !w[31] && ({1'b0, w} < 33'(lim));
   endfunction

   cmd_type cmd;
   assign cmd = cmd_type'(it_ff.command);

   logic rel_ok;
   logic signed [31:0] sx, sy;
   assign sx = x_ff;
   assign sy = y_ff;
   always_comb begin
      unique case (it_ff.relation)
         REL_GT: rel_ok = sx > sy;
         REL_LT: rel_ok = sx < sy;
         REL_EQ: rel_ok = sx == sy;
         REL_NE: rel_ok = sx != sy;
         REL_LE: rel_ok = sx <= sy;
         REL_GE: rel_ok = sx >= sy;
         default: rel_ok = 1'b0;
      endcase
   end

   beu_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(x_ff), .divisor(y_ff),
      .done(div_done), .quotient(div_q), .remainder(div_r)
   );

   logic a_var;
   assign a_var = var_ok(it_ff.word_a);

   always_comb begin
      st_in = st_ff; q_pop = 1'b0; res_in = res_ff; skip_in = skip_ff;
      vaddr = it_ff.word_b[VarBits-1:0]; vwe = 1'b0; vwdata = '0; awe = 1'b0;
      aaddr_in = aaddr_ff; div_start = 1'b0;
      unique case (st_ff)
         ST_IDLE: if (q_valid && !ovalid_ff) begin
            q_pop = 1'b1;
            st_in = ST_RD1;
         end
         ST_RD1: begin
            st_in = ST_RD2;
            vaddr = (cmd == CMD_IF || cmd == CMD_PNUM || cmd == CMD_PCHAR)
                    ? it_ff.word_a[VarBits-1:0] : it_ff.word_b[VarBits-1:0];
         end
         ST_RD2: begin
            st_in = ST_RD3;
            vaddr = (cmd == CMD_IF) ? it_ff.word_b[VarBits-1:0] :
                    (cmd inside {CMD_INC, CMD_DEC}) ? it_ff.word_a[VarBits-1:0] :
                    it_ff.word_c[VarBits-1:0];
         end
         ST_RD3: begin
            st_in = ST_EXEC;
         end
         ST_EXEC: begin
            res_in = '0;
            st_in  = ST_OUT;
            if (skip_ff != '0) begin
               res_in.skipped = 1'b1;
               if (cmd == CMD_IF && skip_ff != '1) skip_in = skip_ff + 1'b1;
               else if (cmd == CMD_END) skip_in = skip_ff - 1'b1;
            end else begin
               unique case (cmd)
                  CMD_SET, CMD_INC, CMD_DEC, CMD_RNUM, CMD_RCHAR: begin
                     vaddr = it_ff.word_a[VarBits-1:0];
                     if (!a_var || ((cmd inside {CMD_SET, CMD_INC, CMD_DEC}) && !xok_ff))
                        res_in.error = ERR_VAR;
                     else begin
                        vwe = 1'b1;
                        unique case (cmd)
                           CMD_SET: vwdata = x_ff;
                           CMD_INC: vwdata = dst_ff + x_ff;
                           CMD_DEC: vwdata = dst_ff - x_ff;
                           CMD_RNUM: vwdata = it_ff.input_value;
                           default: vwdata = {24'd0, it_ff.input_value[7:0]};
                        endcase
                     end
                  end
                  CMD_IF: begin
                     if (!xok_ff || !yok_ff) res_in.error = ERR_VAR;
                     else if (!rel_ok) skip_in = SKIP_BITS'(1);
                  end
                  CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD: begin
                     vaddr = it_ff.word_a[VarBits-1:0];
                     if (!a_var || !xok_ff || !yok_ff) res_in.error = ERR_VAR;
                     else if ((cmd == CMD_DIV || cmd == CMD_MOD) && y_ff == '0)
                        res_in.error = ERR_DIV;
                     else if (cmd == CMD_DIV || cmd == CMD_MOD) begin
                        div_start = 1'b1;
                        st_in = ST_DIV;
                     end else if (cmd == CMD_MUL) begin
                        st_in = ST_MUL;
                     end else begin
                        vwe = 1'b1;
                        vwdata = (cmd == CMD_ADD) ? x_ff + y_ff : x_ff - y_ff;
                     end
                  end
                  CMD_ALLOC: begin
                     if (!xok_ff) res_in.error = ERR_VAR;
                     else if (!cnt_ok(it_ff.word_a, ARRAY_COUNT) ||
                              !cnt_ok(x_ff, ARRAY_DEPTH + 1)) res_in.error = ERR_ARR;
                  end
                  CMD_FREE: if (!cnt_ok(it_ff.word_a, ARRAY_COUNT)) res_in.error = ERR_ARR;
                  CMD_ASTORE: begin
                     if (!xok_ff || !yok_ff) res_in.error = ERR_VAR;
                     else if (!cnt_ok(it_ff.word_a, ARRAY_COUNT) ||
                              !cnt_ok(x_ff, ARRAY_DEPTH)) res_in.error = ERR_ARR;
                     else begin
                        awe = 1'b1;
                        aaddr_in = ArrBits'(it_ff.word_a[NumBits-1:0] * ARRAY_DEPTH +
                                            x_ff[IdxBits-1:0]);
                     end
                  end
                  CMD_ALOAD: begin
                     if (!a_var || !yok_ff) res_in.error = ERR_VAR;
                     else if (!cnt_ok(it_ff.word_b, ARRAY_COUNT) ||
                              !cnt_ok(y_ff, ARRAY_DEPTH)) res_in.error = ERR_ARR;
                     else begin
                        aaddr_in = ArrBits'(it_ff.word_b[NumBits-1:0] * ARRAY_DEPTH +
                                            y_ff[IdxBits-1:0]);
                        st_in = ST_ARD;
                     end
                  end
                  CMD_PNUM, CMD_PCHAR: begin
                     if (!xok_ff) res_in.error = ERR_VAR;
                     else begin
                        res_in.print_kind  = (cmd == CMD_PNUM) ? KIND_NUM : KIND_CHAR;
                        res_in.print_value = x_ff;
                     end
                  end
                  CMD_JUMP: begin
                     res_in.redirect = 1'b1;
                     res_in.redirect_target = it_ff.word_a[15:0];
                  end
                  default: ;
               endcase
            end
         end
         ST_ARD: begin
            st_in = ST_OUT;
         end
         ST_DIV: if (div_done) begin
            vaddr = it_ff.word_a[VarBits-1:0];
            vwe = 1'b1;
            vwdata = (cmd == CMD_DIV) ? div_q : div_r;
            st_in = ST_OUT;
         end
         ST_MUL: begin
            vaddr = it_ff.word_a[VarBits-1:0];
            vwe = 1'b1;
            vwdata = prod_ff;
            st_in = ST_OUT;
         end
         ST_OUT: begin
            if (ald_ff) begin
               vaddr = it_ff.word_a[VarBits-1:0];
               vwe = 1'b1;
               vwdata = ard_ff;
            end
            if (!ovalid_ff || !rsp_stall) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // a delayed load writes its variable in the cycle after the array read, in ST_OUT
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_IDLE;
         skip_ff   <= '0;
         ovalid_ff <= 1'b0;
         ald_ff    <= 1'b0;
      end else begin
         st_ff   <= st_in;
         skip_ff <= skip_in;
         ald_ff  <= (st_ff == ST_ARD);
         if (st_ff == ST_OUT && st_in == ST_IDLE) ovalid_ff <= 1'b1;
         else if (ovalid_ff && !rsp_stall) ovalid_ff <= 1'b0;
      end
      aaddr_ff <= aaddr_in;
      if (q_pop) it_ff <= q_item;
      if (st_ff == ST_EXEC || st_ff == ST_DIV) res_ff <= res_in;
      vrd_ff <= vars_mem[vaddr];
      if (vwe) vars_mem[vaddr] <= vwdata;
      if (awe) arr_mem[aaddr_in] <= y_ff;
      ard_ff <= arr_mem[aaddr_ff];
      prod_ff <= x_ff * y_ff;
      if (st_ff == ST_RD2) begin
         if (cmd == CMD_IF || cmd == CMD_PNUM || cmd == CMD_PCHAR) begin
            x_ff <= it_ff.first_is_var ? vrd_ff : it_ff.word_a;
            xok_ff <= !it_ff.first_is_var || a_var;
         end else begin
            x_ff <= it_ff.first_is_var ? vrd_ff : it_ff.word_b;
            xok_ff <= !it_ff.first_is_var || var_ok(it_ff.word_b);
         end
      end
   end

   // second operand arrives in the cycle after the RD2 address
   always_ff @(posedge clock) begin
      if (st_ff == ST_RD3) begin
         if (cmd == CMD_IF) begin
            y_ff <= it_ff.second_is_var ? vrd_ff : it_ff.word_b;
            yok_ff <= !it_ff.second_is_var || var_ok(it_ff.word_b);
         end else begin
            y_ff <= it_ff.second_is_var ? vrd_ff : it_ff.word_c;
            yok_ff <= !it_ff.second_is_var || var_ok(it_ff.word_c);
         end
         dst_ff <= vrd_ff;
      end
   end

   assign rsp_valid  = ovalid_ff;
   assign rsp_result = res_ff;
endmodule

### src/bytecode_execute_unit.sv
// Top level of the bytecode execute unit.
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | command .. input_value
//  rsp     | out       | rsp_valid/rsp_stall  | print_kind .. error
// After its word is accepted, a result passes queue pop, two variable reads, operand capture,
// execute and output; array load adds the ARD state and multiply the MUL state, and divide
// and modulo wait in the DIV state on the bit-serial divider.
// The engine pops the next word in the cycle after the result is taken, one word at a time.
// Reset is synchronous and clears the queue, skip counter and output valid.
// The front queue holds two words and keeps accepting while a result is stalled, until full.
`timescale 1ns / 1ps
module bytecode_execute_unit
   import beu_pkg::*;
#(
   parameter int VAR_COUNT   = VarCountDef,
   parameter int ARRAY_COUNT = ArrayCountDef,
   parameter int ARRAY_DEPTH = ArrayDepthDef,
   parameter int SKIP_BITS   = SkipBitsDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [4:0]  req_command,
   input  logic [2:0]  req_relation,
   input  logic        req_first_is_var,
   input  logic        req_second_is_var,
   input  logic [31:0] req_word_a,
   input  logic [31:0] req_word_b,
   input  logic [31:0] req_word_c,
   input  logic [31:0] req_input_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_print_kind,
   output logic [31:0] rsp_print_value,
   output logic        rsp_redirect,
   output logic [15:0] rsp_redirect_target,
   output logic        rsp_skipped,
   output logic [1:0]  rsp_error
);
   item_type   req_item, q_item;
   result_type res;
   logic       q_valid, q_pop;

   assign req_item = '{req_command, req_relation, req_first_is_var, req_second_is_var,
                       req_word_a, req_word_b, req_word_c, req_input_value};

   beu_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_item, .q_valid, .q_pop, .q_item
   );

   beu_back #(
      .VAR_COUNT(VAR_COUNT), .ARRAY_COUNT(ARRAY_COUNT),
      .ARRAY_DEPTH(ARRAY_DEPTH), .SKIP_BITS(SKIP_BITS)
   ) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_item, .rsp_valid, .rsp_stall, .rsp_result(res)
   );

   assign rsp_print_kind      = res.print_kind;
   assign rsp_print_value     = res.print_value;
   assign rsp_redirect        = res.redirect;
   assign rsp_redirect_target = res.redirect_target;
   assign rsp_skipped         = res.skipped;
   assign rsp_error           = res.error;
endmodule

### src/beu_checker.sv
// Port-level checks for the bytecode execute unit and their binding.
`timescale 1ns / 1ps
module beu_checker
   import beu_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_print_kind,
   input logic        rsp_redirect,
   input logic [15:0] rsp_redirect_target,
   input logic        rsp_skipped,
   input logic [1:0]  rsp_error
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("rsp valid dropped");
   a_skip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_skipped |-> rsp_error == ERR_NONE && !rsp_redirect &&
      rsp_print_kind == KIND_NONE) else $error("skipped word has effects");
   a_redir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_redirect |-> rsp_redirect_target == '0)
      else $error("stray target");
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_print_kind != KIND_NONE |-> rsp_error == ERR_NONE)
      else $error("print with error");
endmodule

bind bytecode_execute_unit beu_checker u_beu_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_print_kind, .rsp_redirect,
   .rsp_redirect_target, .rsp_skipped, .rsp_error
);
